FILE: sv/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constants for the amicable pair checker.
// ----------------------------------------------------------------------------
package apc_pkg;

    // Width of each input number field on the ports
    localparam int IN_WIDTH            = 16;
    // Width of each reported divisor sum, and its saturation value
    localparam int SUM_WIDTH           = 18;
    localparam int SUM_MAX             = 262143;
    // Default operand width used by the datapath
    localparam int VALUE_WIDTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT,
        ST_DONE
    } apc_state_t;

    // Status of the shared remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

endpackage

FILE: sv/apc_rem_unit.sv
// ----------------------------------------------------------------------------
// apc_rem_unit
// Bit-serial restoring remainder: dividend % divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module apc_rem_unit
    import apc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output rem_status_t            status,
    output logic [VALUE_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [VALUE_WIDTH-1:0] shift_reg;
    logic [VALUE_WIDTH-1:0] divisor_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] rem_next;

    // Shift in the next dividend bit, subtract when the divisor fits
    always_comb begin
        trial = {rem_reg, shift_reg[VALUE_WIDTH-1]};
        if (trial >= {1'b0, divisor_reg}) begin
            rem_next = VALUE_WIDTH'(trial - {1'b0, divisor_reg});
        end else begin
            rem_next = trial[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(VALUE_WIDTH);
            end else if (busy_reg) begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg   <= dividend;
            divisor_reg <= divisor;
            rem_reg     <= '0;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

FILE: sv/amicable_pair_check.sv
// ----------------------------------------------------------------------------
// amicable_pair_check
// Aliquot sums of two numbers by trial division, with an amicable verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item carries number_a and number_b. The block takes
//   an item only when s_ready is high, which is only while it is idle.
//   Result channel m_*: one item per input item, held in an output register
//   until m_ready takes it. A new input item may be taken while a result still
//   waits; the next result is then held back until the register frees up.
//   For each number n the block tries divisors d = 1 .. n/2 and adds every d
//   that leaves no remainder, saturating the sum at its maximum.
//   The remainders come from one shared bit-serial unit, one trial divisor at
//   a time. An item with a zero number finishes with bad_input set and all
//   else zero.
//   Throughput: one item at a time, the next accepted once the result is
//   loaded into the output register.
//   Reset (aresetn low, synchronous) drops any item at work and any pending
//   result and returns the block to idle.
// ----------------------------------------------------------------------------
module amicable_pair_check
    import apc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_WIDTH-1:0]  s_number_a,
    input  logic [IN_WIDTH-1:0]  s_number_b,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_are_amicable,
    output logic [SUM_WIDTH-1:0] m_divisor_sum_a,
    output logic [SUM_WIDTH-1:0] m_divisor_sum_b,
    output logic                 m_bad_input
);

    // Common width for comparing sums against operands
    localparam int CW = (SUM_WIDTH > VALUE_WIDTH) ? SUM_WIDTH : VALUE_WIDTH;
    localparam logic [CW:0] SUM_MAX_W = (CW + 1)'(SUM_MAX);

    apc_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] number_a_reg;
    logic [VALUE_WIDTH-1:0] number_b_reg;
    logic [VALUE_WIDTH-1:0] trial_divisor_reg;
    logic [SUM_WIDTH-1:0]   running_sum_reg;
    logic [SUM_WIDTH-1:0]   sum_a_reg;
    logic                   which_operand_reg;
    logic                   bad_reg;

    logic                   m_valid_reg;
    logic                   m_are_amicable_reg;
    logic [SUM_WIDTH-1:0]   m_divisor_sum_a_reg;
    logic [SUM_WIDTH-1:0]   m_divisor_sum_b_reg;
    logic                   m_bad_input_reg;

    logic [VALUE_WIDTH-1:0] in_a;
    logic [VALUE_WIDTH-1:0] in_b;
    logic                   in_zero;
    logic [VALUE_WIDTH-1:0] operand;
    logic [VALUE_WIDTH-1:0] half;
    logic                   scan_done;
    logic                   rem_start;
    rem_status_t            rem_status;
    logic [VALUE_WIDTH-1:0] remainder;
    logic [CW:0]            sum_wide;
    logic [SUM_WIDTH-1:0]   sum_sat;
    logic                   out_free;
    logic                   amicable;

    // Keep only the low VALUE_WIDTH bits of each number
    assign in_a    = VALUE_WIDTH'(s_number_a);
    assign in_b    = VALUE_WIDTH'(s_number_b);
    assign in_zero = (in_a == '0) || (in_b == '0);

    // Current operand and its trial limit
    assign operand   = which_operand_reg ? number_b_reg : number_a_reg;
    assign half      = operand >> 1;
    assign scan_done = trial_divisor_reg > half;

    // Saturating accumulate of the current trial divisor
    assign sum_wide = (CW + 1)'(running_sum_reg) + (CW + 1)'(trial_divisor_reg);
    assign sum_sat  = (sum_wide > SUM_MAX_W) ? SUM_WIDTH'(SUM_MAX)
                                             : sum_wide[SUM_WIDTH-1:0];

    assign out_free = !m_valid_reg || m_ready;

    // Verdict: each sum must equal the other number
    assign amicable = (CW'(sum_a_reg) == CW'(number_b_reg)) &&
                      (CW'(running_sum_reg) == CW'(number_a_reg));

    apc_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (operand),
        .divisor   (trial_divisor_reg),
        .status    (rem_status),
        .remainder (remainder)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state and the remainder unit start strobe
    always_comb begin
        state_next = state_reg;
        rem_start  = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = in_zero ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (scan_done) begin
                    if (which_operand_reg) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    rem_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (rem_status.done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath registers, advanced by the sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trial_divisor_reg <= '0;
            running_sum_reg   <= '0;
            which_operand_reg <= 1'b0;
            bad_reg           <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        number_a_reg      <= in_a;
                        number_b_reg      <= in_b;
                        bad_reg           <= in_zero;
                        which_operand_reg <= 1'b0;
                        trial_divisor_reg <= VALUE_WIDTH'(1);
                        running_sum_reg   <= '0;
                    end
                end
                ST_CHECK: begin
                    // First operand finished: park its sum, restart on the second
                    if (scan_done && !which_operand_reg) begin
                        sum_a_reg         <= running_sum_reg;
                        running_sum_reg   <= '0;
                        trial_divisor_reg <= VALUE_WIDTH'(1);
                        which_operand_reg <= 1'b1;
                    end
                end
                ST_WAIT: begin
                    if (rem_status.done) begin
                        if (remainder == '0) begin
                            running_sum_reg <= sum_sat;
                        end
                        trial_divisor_reg <= trial_divisor_reg + VALUE_WIDTH'(1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        trial_divisor_reg <= '0;
                        running_sum_reg   <= '0;
                        which_operand_reg <= 1'b0;
                    end
                end
                default: begin
                    trial_divisor_reg <= '0;
                end
            endcase
        end
    end

    // Output register: load on finish, hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_bad_input_reg <= bad_reg;
            if (bad_reg) begin
                m_are_amicable_reg  <= 1'b0;
                m_divisor_sum_a_reg <= '0;
                m_divisor_sum_b_reg <= '0;
            end else begin
                m_are_amicable_reg  <= amicable;
                m_divisor_sum_a_reg <= sum_a_reg;
                m_divisor_sum_b_reg <= running_sum_reg;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_are_amicable  = m_are_amicable_reg;
    assign m_divisor_sum_a = m_divisor_sum_a_reg;
    assign m_divisor_sum_b = m_divisor_sum_b_reg;
    assign m_bad_input     = m_bad_input_reg;

endmodule

FILE: sv/apc_checker.sv
// ----------------------------------------------------------------------------
// apc_checker
// Port-level checks for the amicable pair checker, bound to the top level.
// ----------------------------------------------------------------------------
module apc_checker
    import apc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [IN_WIDTH-1:0]  s_number_a,
    input logic [IN_WIDTH-1:0]  s_number_b,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_are_amicable,
    input logic [SUM_WIDTH-1:0] m_divisor_sum_a,
    input logic [SUM_WIDTH-1:0] m_divisor_sum_b,
    input logic                 m_bad_input
);

    // One item at a time: an accepted item blocks the input next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after an accepted item");

    // Hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_divisor_sum_a) &&
            $stable(m_divisor_sum_b) && $stable(m_are_amicable) &&
            $stable(m_bad_input)))
        else $error("stalled result changed");

    // Zero input clears every other field
    a_bad_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_input) |->
            (!m_are_amicable && m_divisor_sum_a == '0 && m_divisor_sum_b == '0))
        else $error("bad input result carries nonzero fields");

    // An amicable pair has nonzero sums on both sides
    a_amicable_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_are_amicable) |->
            (!m_bad_input && m_divisor_sum_a != '0 && m_divisor_sum_b != '0))
        else $error("amicable verdict with a zero sum");

endmodule

bind amicable_pair_check apc_checker u_apc_checker (.*);
